// ===== design/rbd_pkg.sv =====
// rbd_pkg: shared types and codes for the ring buffer deque
// no dependencies; used by the interfaces, controller, datapath and top level

package rbd_pkg;

	localparam int MODE_W = 2;
	localparam int VALUE_W = 32;
	localparam int CAP_W = 7;
	localparam int COUNT_W = 7;
	localparam int INDEX_W = 6;
	localparam int ERR_W = 2;
	localparam int FILL_W = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

	localparam logic [FILL_W-1:0] FILL_NEITHER = 2'd0;
	localparam logic [FILL_W-1:0] FILL_FULL    = 2'd1;
	localparam logic [FILL_W-1:0] FILL_EMPTY   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load_direct;
		logic load_mem;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop_go;
	} stat_t;

endpackage

// ===== design/rbd_if.sv =====
// rbd_if: request and response channel interfaces of the ring buffer deque
// depends on rbd_pkg for field widths

interface rbd_req_if;
	logic                             valid;
	logic                             ready;
	logic [rbd_pkg::MODE_W-1:0]       mode;
	logic signed [rbd_pkg::VALUE_W-1:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface rbd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [rbd_pkg::VALUE_W-1:0] popped_value;
	logic [rbd_pkg::ERR_W-1:0]          error_code;
	logic [rbd_pkg::COUNT_W-1:0]        item_count;
	logic [rbd_pkg::INDEX_W-1:0]        front_index;
	logic [rbd_pkg::INDEX_W-1:0]        rear_index;
	logic [rbd_pkg::FILL_W-1:0]         fill_status;

	modport source (output valid, output popped_value, output error_code, output item_count,
		output front_index, output rear_index, output fill_status, input ready);
	modport sink (input valid, input popped_value, input error_code, input item_count,
		input front_index, input rear_index, input fill_status, output ready);
endinterface

// ===== design/rbd_ram.sv =====
// rbd_ram: generic single write port, single read port ram with registered read
// no dependencies

module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/rbd_ctrl.sv =====
// rbd_ctrl: request acceptance and response valid control of the ring buffer deque
// depends on rbd_pkg for the command and status structs

module rbd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  rbd_pkg::stat_t stat,
	output rbd_pkg::cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;

	always_comb begin
		req_ready       = 1'b0;
		cmd.take        = 1'b0;
		cmd.load_direct = 1'b0;
		cmd.load_mem    = 1'b0;
		state_d         = state_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				cmd.take  = req_valid && req_ready;
				if (cmd.take) begin
					if (stat.pop_go) begin
						state_d = ST_READ;
					end else begin
						cmd.load_direct = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.load_mem = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_direct || cmd.load_mem) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/rbd_dp.sv =====
// rbd_dp: pointers, count, capacity register, ring ram and response register
// depends on rbd_pkg and rbd_ram

module rbd_dp #(
	parameter int DEPTH = 64,
	parameter int DATA_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rbd_pkg::MODE_W-1:0]          req_mode,
	input  logic signed [rbd_pkg::VALUE_W-1:0]  req_push_value,
	input  logic                                cfg_we,
	input  logic [rbd_pkg::CAP_W-1:0]           cfg_wdata,
	input  rbd_pkg::cmd_t                       cmd,
	output rbd_pkg::stat_t                      stat,
	output logic signed [rbd_pkg::VALUE_W-1:0]  popped_value,
	output logic [rbd_pkg::ERR_W-1:0]           error_code,
	output logic [rbd_pkg::COUNT_W-1:0]         item_count,
	output logic [rbd_pkg::INDEX_W-1:0]         front_index,
	output logic [rbd_pkg::INDEX_W-1:0]         rear_index,
	output logic [rbd_pkg::FILL_W-1:0]          fill_status
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > rbd_pkg::CAP_W) ? CW : rbd_pkg::CAP_W;
	localparam int IW = (PW > rbd_pkg::INDEX_W) ? PW : rbd_pkg::INDEX_W;
	localparam int XW = (DATA_BITS > rbd_pkg::VALUE_W) ? DATA_BITS : rbd_pkg::VALUE_W;
	localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

	logic [rbd_pkg::CAP_W-1:0] cap_q;
	logic [PW-1:0]             front_q;
	logic [PW-1:0]             back_q;
	logic [CW-1:0]             count_q;

	logic [MW-1:0]         cap_m;
	logic [MW-1:0]         eff_m;
	logic [CW-1:0]         eff_cap;
	logic                  full;
	logic                  empty;
	logic [PW-1:0]         front_d;
	logic [PW-1:0]         back_d;
	logic [CW-1:0]         count_d;
	logic [rbd_pkg::ERR_W-1:0] err_d;
	logic                  wr_go;
	logic [PW-1:0]         waddr;
	logic [PW-1:0]         raddr;
	logic [PW-1:0]         rear_d;
	logic [rbd_pkg::FILL_W-1:0] fill_d;
	logic [XW-1:0]         push_x;
	logic [DATA_BITS-1:0]  wdata;
	logic [DATA_BITS-1:0]  rdata;
	logic [XW-1:0]         rdata_x;
	logic [MW-1:0]         count_m;
	logic [IW-1:0]         front_x;
	logic [IW-1:0]         rear_x;

	logic signed [rbd_pkg::VALUE_W-1:0] popped_q;
	logic [rbd_pkg::ERR_W-1:0]          err_q;
	logic [rbd_pkg::COUNT_W-1:0]        item_count_q;
	logic [rbd_pkg::INDEX_W-1:0]        front_index_q;
	logic [rbd_pkg::INDEX_W-1:0]        rear_index_q;
	logic [rbd_pkg::FILL_W-1:0]         fill_q;

	function automatic logic [PW-1:0] dec_wrap(input logic [PW-1:0] p, input logic [CW-1:0] c);
		logic [CW-1:0] last;
		last = c - CW'(1);
		return (p == '0) ? last[PW-1:0] : p - PW'(1);
	endfunction

	function automatic logic [PW-1:0] inc_wrap(input logic [PW-1:0] p, input logic [CW-1:0] c);
		logic [CW-1:0] nxt;
		nxt = CW'(p) + CW'(1);
		return (nxt >= c) ? '0 : nxt[PW-1:0];
	endfunction

	// effective capacity: zero acts as one, clamp to the ring depth
	assign cap_m   = MW'(cap_q);
	assign eff_m   = (cap_m == '0) ? MW'(1) : ((cap_m > DEPTH_M) ? DEPTH_M : cap_m);
	assign eff_cap = eff_m[CW-1:0];
	assign full    = (count_q >= eff_cap);
	assign empty   = (count_q == '0);

	always_comb begin
		front_d = front_q;
		back_d  = back_q;
		count_d = count_q;
		err_d   = rbd_pkg::ERR_NONE;
		wr_go   = 1'b0;
		waddr   = back_q;
		raddr   = front_q;
		stat.pop_go  = 1'b0;
		unique case (req_mode)
			rbd_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					err_d = rbd_pkg::ERR_OVERFLOW;
				end else begin
					front_d = dec_wrap(front_q, eff_cap);
					waddr   = front_d;
					wr_go   = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			rbd_pkg::MODE_PUSH_BACK: begin
				if (full) begin
					err_d = rbd_pkg::ERR_OVERFLOW;
				end else begin
					waddr   = back_q;
					back_d  = inc_wrap(back_q, eff_cap);
					wr_go   = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			rbd_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					err_d = rbd_pkg::ERR_UNDERFLOW;
				end else begin
					raddr       = front_q;
					front_d     = inc_wrap(front_q, eff_cap);
					count_d     = count_q - CW'(1);
					stat.pop_go = 1'b1;
				end
			end
			rbd_pkg::MODE_POP_BACK: begin
				if (empty) begin
					err_d = rbd_pkg::ERR_UNDERFLOW;
				end else begin
					back_d      = dec_wrap(back_q, eff_cap);
					raddr       = back_d;
					count_d     = count_q - CW'(1);
					stat.pop_go = 1'b1;
				end
			end
			default: begin
				err_d = rbd_pkg::ERR_NONE;
			end
		endcase
	end

	assign rear_d = dec_wrap(back_d, eff_cap);

	always_comb begin
		priority if (count_d == eff_cap) begin
			fill_d = rbd_pkg::FILL_FULL;
		end else if (count_d == '0) begin
			fill_d = rbd_pkg::FILL_EMPTY;
		end else begin
			fill_d = rbd_pkg::FILL_NEITHER;
		end
	end

	assign push_x  = XW'(unsigned'(req_push_value));
	assign wdata   = push_x[DATA_BITS-1:0];
	assign rdata_x = XW'(rdata);
	assign count_m = MW'(count_d);
	assign front_x = IW'(front_d);
	assign rear_x  = IW'(rear_d);

	rbd_ram #(
		.WIDTH(DATA_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.take && wr_go),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.take && stat.pop_go),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= rbd_pkg::CAP_RESET;
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_wdata;
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			err_q         <= err_d;
			item_count_q  <= count_m[rbd_pkg::COUNT_W-1:0];
			front_index_q <= front_x[rbd_pkg::INDEX_W-1:0];
			rear_index_q  <= rear_x[rbd_pkg::INDEX_W-1:0];
			fill_q        <= fill_d;
		end
		if (cmd.load_direct) begin
			popped_q <= '0;
		end else if (cmd.load_mem) begin
			popped_q <= signed'(rdata_x[rbd_pkg::VALUE_W-1:0]);
		end
	end

	assign popped_value = popped_q;
	assign error_code   = err_q;
	assign item_count   = item_count_q;
	assign front_index  = front_index_q;
	assign rear_index   = rear_index_q;
	assign fill_status  = fill_q;

endmodule

// ===== design/ring_buffer_deque_core.sv =====
// ring_buffer_deque_core: top level of the circular double-ended queue
// depends on rbd_pkg, rbd_if, rbd_ram, rbd_ctrl and rbd_dp

// Each request pushes at the front or back, or pops from the front or back, of a ring of
// DEPTH entries of which cfg_wdata (written through cfg_we, zero acting as one, clamped to
// DEPTH) are in use; any capacity write empties the deque. Exactly one response follows
// every request. A push, or any refused request, has its response in the cycle after
// acceptance and the next request may be taken in that same cycle, so pushes run at one
// per cycle while responses are taken. A successful pop reads the ring ram, whose read is
// registered, so the controller passes through its read state, taking no request, and
// registers the ram output as the response. The ram needs no clearing pass after reset.

module ring_buffer_deque_core #(
	parameter int DEPTH = 64,
	parameter int DATA_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rbd_req_if.sink                     req,
	rbd_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [rbd_pkg::CAP_W-1:0]   cfg_wdata
);

	rbd_pkg::cmd_t  cmd;
	rbd_pkg::stat_t stat;

	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbd_dp #(
		.DEPTH     (DEPTH),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_mode       (req.mode),
		.req_push_value (req.push_value),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.stat           (stat),
		.popped_value   (rsp.popped_value),
		.error_code     (rsp.error_code),
		.item_count     (rsp.item_count),
		.front_index    (rsp.front_index),
		.rear_index     (rsp.rear_index),
		.fill_status    (rsp.fill_status)
	);

`ifndef SYNTHESIS
	// a ram read return never coincides with a new request
	a_no_take_on_return: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mem |-> !cmd.take)
		else $error("request taken while a pop read returns");

	// a read return always follows a successful pop in the next cycle
	a_return_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && stat.pop_go |=> cmd.load_mem)
		else $error("pop read did not return");

	// a refused request reports zero as popped value
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error_code != rbd_pkg::ERR_NONE |-> rsp.popped_value == '0)
		else $error("refused request returned a value");

	// an empty status always goes with a zero count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.fill_status == rbd_pkg::FILL_EMPTY |-> rsp.item_count == '0)
		else $error("empty status with nonzero count");
`endif

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for ring_buffer_deque_core, with directed and random requests
// depends on rbd_pkg, rbd_if and the core; keeps its own model of the deque for checking

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 750;
	localparam int STALL_LIMIT = 2000;
	localparam int RING_SLOTS = 64;

	typedef struct packed {
		logic signed [rbd_pkg::VALUE_W-1:0] popped;
		logic [rbd_pkg::ERR_W-1:0]          err;
		logic [rbd_pkg::COUNT_W-1:0]        count;
		logic [rbd_pkg::INDEX_W-1:0]        front;
		logic [rbd_pkg::INDEX_W-1:0]        rear;
		logic [rbd_pkg::FILL_W-1:0]         fill;
	} deque_result_t;

	typedef struct packed {
		logic                               is_cfg;
		logic [rbd_pkg::CAP_W-1:0]          cap_val;
		logic [rbd_pkg::MODE_W-1:0]         mode;
		logic signed [rbd_pkg::VALUE_W-1:0] value;
		logic                               typed;
		deque_result_t                      want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [rbd_pkg::CAP_W-1:0] cfg_wdata;

	rbd_req_if request_bus ();
	rbd_rsp_if response_bus ();

	ring_buffer_deque_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (request_bus),
		.rsp       (response_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the deque
	logic signed [rbd_pkg::VALUE_W-1:0] ring_copy [RING_SLOTS];
	int head_ptr = 0;
	int tail_ptr = 0;
	int held = 0;
	logic [rbd_pkg::CAP_W-1:0] cap_reg = rbd_pkg::CAP_RESET;

	deque_result_t awaited_results [$];
	int fault_count = 0;
	bit no_idle = 1'b0;

	stim_row_t directed_rows [25] = '{
		// empty after reset
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_FRONT, 32'sd0, 1'b1,
			'{32'sd0, rbd_pkg::ERR_UNDERFLOW, 7'd0, 6'd0, 6'd63, rbd_pkg::FILL_EMPTY}},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_BACK, 32'sd0, 1'b1,
			'{32'sd0, rbd_pkg::ERR_UNDERFLOW, 7'd0, 6'd0, 6'd63, rbd_pkg::FILL_EMPTY}},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 1'b1,
			'{32'sd0, rbd_pkg::ERR_NONE, 7'd1, 6'd0, 6'd0, rbd_pkg::FILL_NEITHER}},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 1'b1,
			'{32'sd0, rbd_pkg::ERR_NONE, 7'd2, 6'd63, 6'd0, rbd_pkg::FILL_NEITHER}},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_BACK, 32'sd0, 1'b1,
			'{32'h7fff_ffff, rbd_pkg::ERR_NONE, 7'd1, 6'd63, 6'd63, rbd_pkg::FILL_NEITHER}},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_FRONT, 32'sd0, 1'b1,
			'{32'h8000_0000, rbd_pkg::ERR_NONE, 7'd0, 6'd0, 6'd63, rbd_pkg::FILL_EMPTY}},
		// single slot
		'{1'b1, 7'd1, rbd_pkg::MODE_PUSH_FRONT, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 1'b1,
			'{32'sd0, rbd_pkg::ERR_NONE, 7'd1, 6'd0, 6'd0, rbd_pkg::FILL_FULL}},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_BACK, 32'sd0, 1'b1,
			'{32'sd0, rbd_pkg::ERR_OVERFLOW, 7'd1, 6'd0, 6'd0, rbd_pkg::FILL_FULL}},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_FRONT, 32'sd0, 1'b1,
			'{32'sd0, rbd_pkg::ERR_OVERFLOW, 7'd1, 6'd0, 6'd0, rbd_pkg::FILL_FULL}},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_BACK, 32'sd0, 1'b1,
			'{32'hffff_ffff, rbd_pkg::ERR_NONE, 7'd0, 6'd0, 6'd0, rbd_pkg::FILL_EMPTY}},
		// zero capacity behaves as one
		'{1'b1, 7'd0, rbd_pkg::MODE_PUSH_FRONT, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_BACK, 32'sd1, 1'b1,
			'{32'sd0, rbd_pkg::ERR_NONE, 7'd1, 6'd0, 6'd0, rbd_pkg::FILL_FULL}},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_FRONT, 32'sd0, 1'b1,
			'{32'sd1, rbd_pkg::ERR_NONE, 7'd0, 6'd0, 6'd0, rbd_pkg::FILL_EMPTY}},
		// oversized capacity clamps to the ring
		'{1'b1, 7'd127, rbd_pkg::MODE_PUSH_FRONT, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_BACK, 32'h5555_5555, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_FRONT, 32'haaaa_aaaa, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_FRONT, 32'sd0, 1'b0, '0},
		// two slots, wrap both ways
		'{1'b1, 7'd2, rbd_pkg::MODE_PUSH_FRONT, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_FRONT, 32'h1234_5678, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_BACK, 32'h9abc_def0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_PUSH_BACK, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_BACK, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_FRONT, 32'sd0, 1'b0, '0},
		'{1'b0, 7'd0, rbd_pkg::MODE_POP_BACK, 32'sd0, 1'b0, '0}
	};

	function automatic deque_result_t deque_predict(input logic [rbd_pkg::MODE_W-1:0] m,
			input logic signed [rbd_pkg::VALUE_W-1:0] v);
		deque_result_t r;
		int lim;
		lim = (cap_reg == 0) ? 1 : ((cap_reg > RING_SLOTS) ? RING_SLOTS : int'(cap_reg));
		r = '0;
		r.err = rbd_pkg::ERR_NONE;
		if (head_ptr >= lim) head_ptr = 0;
		if (tail_ptr >= lim) tail_ptr = 0;
		if (held > lim) held = lim;
		case (m)
			rbd_pkg::MODE_PUSH_FRONT: begin
				if (held >= lim) begin
					r.err = rbd_pkg::ERR_OVERFLOW;
				end else begin
					head_ptr = (head_ptr == 0) ? lim - 1 : head_ptr - 1;
					ring_copy[head_ptr] = v;
					held++;
				end
			end
			rbd_pkg::MODE_PUSH_BACK: begin
				if (held >= lim) begin
					r.err = rbd_pkg::ERR_OVERFLOW;
				end else begin
					ring_copy[tail_ptr] = v;
					tail_ptr = (tail_ptr + 1 >= lim) ? 0 : tail_ptr + 1;
					held++;
				end
			end
			rbd_pkg::MODE_POP_FRONT: begin
				if (held == 0) begin
					r.err = rbd_pkg::ERR_UNDERFLOW;
				end else begin
					r.popped = ring_copy[head_ptr];
					head_ptr = (head_ptr + 1 >= lim) ? 0 : head_ptr + 1;
					held--;
				end
			end
			default: begin
				if (held == 0) begin
					r.err = rbd_pkg::ERR_UNDERFLOW;
				end else begin
					tail_ptr = (tail_ptr == 0) ? lim - 1 : tail_ptr - 1;
					r.popped = ring_copy[tail_ptr];
					held--;
				end
			end
		endcase
		r.count = rbd_pkg::COUNT_W'(held);
		r.front = rbd_pkg::INDEX_W'(head_ptr);
		r.rear = rbd_pkg::INDEX_W'((tail_ptr == 0) ? lim - 1 : tail_ptr - 1);
		if (held == lim) r.fill = rbd_pkg::FILL_FULL;
		else if (held == 0) r.fill = rbd_pkg::FILL_EMPTY;
		else r.fill = rbd_pkg::FILL_NEITHER;
		return r;
	endfunction

	task automatic send_request(input logic [rbd_pkg::MODE_W-1:0] m,
			input logic signed [rbd_pkg::VALUE_W-1:0] v,
			input logic use_typed, input deque_result_t typed_want);
		int gap;
		deque_result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			request_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_bus.valid <= 1'b1;
		request_bus.mode <= m;
		request_bus.push_value <= v;
		do @(posedge clk); while (!request_bus.ready);
		predicted = deque_predict(m, v);
		awaited_results.insert(awaited_results.size(), use_typed ? typed_want : predicted);
	endtask

	// capacity writes only once the deque has drained its responses
	task automatic apply_capacity(input logic [rbd_pkg::CAP_W-1:0] c);
		request_bus.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = c;
		head_ptr = 0;
		tail_ptr = 0;
		held = 0;
	endtask

	// response side
	initial begin
		int stall;
		deque_result_t got;
		deque_result_t want;
		response_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				response_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			response_bus.ready <= 1'b1;
			do @(posedge clk); while (!response_bus.valid);
			got = '{response_bus.popped_value, response_bus.error_code,
				response_bus.item_count, response_bus.front_index,
				response_bus.rear_index, response_bus.fill_status};
			if (awaited_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("response with no request outstanding at %0t", $time);
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch at %0t: want pop %h err %0d count %0d front %0d rear %0d fill %0d",
							$time, want.popped, want.err, want.count, want.front, want.rear,
							want.fill);
						$display("                 got pop %h err %0d count %0d front %0d rear %0d fill %0d",
							got.popped, got.err, got.count, got.front, got.rear, got.fill);
					end
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	initial begin
		int idle_run;
		idle_run = 0;
		@(posedge arst_n);
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if ((request_bus.valid && request_bus.ready)
					|| (response_bus.valid && response_bus.ready) || cfg_we)
				idle_run = 0;
			else
				idle_run++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int random_sent;
		int phase;
		int phase_len;
		int seg_left;
		int push_bias;
		logic [rbd_pkg::MODE_W-1:0] m;
		logic [rbd_pkg::CAP_W-1:0] c;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= rbd_pkg::CAP_RESET;
		request_bus.valid <= 1'b0;
		request_bus.mode <= rbd_pkg::MODE_PUSH_FRONT;
		request_bus.push_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				apply_capacity(directed_rows[i].cap_val);
			else
				send_request(directed_rows[i].mode, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].want);
		end

		random_sent = 0;
		phase = 0;
		seg_left = 0;
		push_bias = 50;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase % 6)
				0: c = rbd_pkg::CAP_RESET;
				1: c = rbd_pkg::CAP_W'($urandom_range(2, 8));
				2: c = rbd_pkg::CAP_W'($urandom_range(9, 63));
				3: c = $urandom_range(0, 1) ? 7'd127 : rbd_pkg::CAP_W'($urandom_range(65, 126));
				4: c = rbd_pkg::CAP_W'($urandom_range(0, 1));
				default: c = rbd_pkg::CAP_W'($urandom_range(1, 64));
			endcase
			no_idle = 1'b0;
			apply_capacity(c);
			phase_len = $urandom_range(60, 160);
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				// runs of push-heavy and pop-heavy traffic to reach full and empty
				if (seg_left == 0) begin
					seg_left = $urandom_range(4, 90);
					case ($urandom_range(0, 2))
						0: push_bias = 85;
						1: push_bias = 15;
						default: push_bias = 50;
					endcase
					no_idle = ($urandom_range(0, 3) == 0);
				end
				seg_left--;
				if ($urandom_range(1, 100) <= push_bias)
					m = $urandom_range(0, 1) ? rbd_pkg::MODE_PUSH_BACK : rbd_pkg::MODE_PUSH_FRONT;
				else
					m = $urandom_range(0, 1) ? rbd_pkg::MODE_POP_BACK : rbd_pkg::MODE_POP_FRONT;
				send_request(m, $urandom, 1'b0, '0);
				random_sent++;
			end
			phase++;
		end

		request_bus.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		fault_count += awaited_results.size();
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rbd_pkg.sv
design/rbd_if.sv
design/rbd_ram.sv
design/rbd_ctrl.sv
design/rbd_dp.sv
design/ring_buffer_deque_core.sv
tb/tb_top.sv
